[src/svf_pkg.sv]
// shared types, constants and the step program of the two-pole filter
// no dependencies; used by svf_alu, svf_ctrl and two_pole_multimode_svf_top
package svf_pkg;

    localparam int FRAC       = 24;
    localparam int K_A        = 173799;
    localparam int K_B        = 154490;
    localparam int K_C        = 3103785;
    localparam int K_D        = 838861;
    localparam int K_X        = 1469684;
    localparam int K_PUSH     = 17364419;
    localparam int K_GAIN     = 12415140;
    localparam int K_HALF     = 8388608;
    localparam int K_ONE      = 16777216;
    localparam int GAIN_RESET = 16777216;

    localparam logic [2:0] CFG_GAIN_START = 3'd0;
    localparam logic [2:0] CFG_DAMP_START = 3'd1;
    localparam logic [2:0] CFG_GAIN_STEP  = 3'd2;
    localparam logic [2:0] CFG_DAMP_STEP  = 3'd3;
    localparam logic [2:0] CFG_MODE       = 3'd4;

    localparam logic [1:0] MODE_LP    = 2'd0;
    localparam logic [1:0] MODE_BP    = 2'd1;
    localparam logic [1:0] MODE_HP    = 2'd2;
    localparam logic [1:0] MODE_NOTCH = 2'd3;

    localparam int PROG_LEN = 34;
    localparam int PC_W     = 6;

    typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV} alu_op_t;
    typedef enum logic [1:0] {AS_IDLE, AS_MUL, AS_DIV, AS_DONE} alu_state_t;
    typedef enum logic [1:0] {CS_IDLE, CS_ISSUE, CS_WAIT, CS_FIN} ctrl_state_t;

    typedef enum logic [4:0] {
        SRC_S1, SRC_S2, SRC_GAIN, SRC_DAMP, SRC_SAMP, SRC_GSTEP, SRC_DSTEP,
        SRC_X, SRC_P, SRC_RT, SRC_T, SRC_N, SRC_D, SRC_V, SRC_Y1, SRC_Y2, SRC_A,
        SRC_KA, SRC_KB, SRC_KC, SRC_KD, SRC_KX, SRC_KONE, SRC_KFB, SRC_KHALF,
        SRC_KGAIN, SRC_YSEL, SRC_MSEL
    } src_t;

    typedef enum logic [3:0] {
        DST_S1, DST_S2, DST_GAIN, DST_DAMP, DST_X, DST_P, DST_RT, DST_T,
        DST_N, DST_D, DST_V, DST_Y1, DST_Y2, DST_A, DST_M
    } dst_t;

    typedef enum logic [1:0] {COND_ALWAYS, COND_HALF, COND_NOTCH} cond_t;

    typedef struct packed {
        alu_op_t op;
        src_t    src_a;
        src_t    src_b;
        dst_t    dst;
        cond_t   cond;
    } step_t;

    typedef struct packed {
        logic    in_ready;
        logic    start;
        alu_op_t op;
        src_t    src_a;
        src_t    src_b;
        logic    wr_en;
        dst_t    dst;
        logic    out_load;
    } ctrl_t;

    function automatic step_t mk(input alu_op_t op, input src_t a, input src_t b,
                                 input dst_t d, input cond_t c);
        step_t s;
        s.op    = op;
        s.src_a = a;
        s.src_b = b;
        s.dst   = d;
        s.cond  = c;
        return s;
    endfunction

    function automatic step_t prog_step(input logic [PC_W-1:0] pc);
        step_t s;
        unique case (pc)
            6'd0:  s = mk(ALU_ADD, SRC_GAIN, SRC_GSTEP, DST_GAIN, COND_ALWAYS);
            6'd1:  s = mk(ALU_ADD, SRC_DAMP, SRC_DSTEP, DST_DAMP, COND_ALWAYS);
            6'd2:  s = mk(ALU_MUL, SRC_S1,   SRC_KX,    DST_X,    COND_ALWAYS);
            6'd3:  s = mk(ALU_MUL, SRC_KA,   SRC_X,     DST_P,    COND_ALWAYS);
            6'd4:  s = mk(ALU_ADD, SRC_P,    SRC_KB,    DST_P,    COND_ALWAYS);
            6'd5:  s = mk(ALU_MUL, SRC_P,    SRC_X,     DST_P,    COND_ALWAYS);
            6'd6:  s = mk(ALU_ADD, SRC_P,    SRC_KC,    DST_P,    COND_ALWAYS);
            6'd7:  s = mk(ALU_MUL, SRC_P,    SRC_X,     DST_P,    COND_ALWAYS);
            6'd8:  s = mk(ALU_ADD, SRC_P,    SRC_KD,    DST_P,    COND_ALWAYS);
            6'd9:  s = mk(ALU_MUL, SRC_P,    SRC_X,     DST_P,    COND_ALWAYS);
            6'd10: s = mk(ALU_ADD, SRC_P,    SRC_KONE,  DST_P,    COND_ALWAYS);
            6'd11: s = mk(ALU_SUB, SRC_P,    SRC_KFB,   DST_P,    COND_ALWAYS);
            6'd12: s = mk(ALU_ADD, SRC_DAMP, SRC_P,     DST_RT,   COND_ALWAYS);
            6'd13: s = mk(ALU_MUL, SRC_S1,   SRC_RT,    DST_T,    COND_ALWAYS);
            6'd14: s = mk(ALU_ADD, SRC_T,    SRC_T,     DST_T,    COND_ALWAYS);
            6'd15: s = mk(ALU_SUB, SRC_SAMP, SRC_T,     DST_N,    COND_ALWAYS);
            6'd16: s = mk(ALU_MUL, SRC_GAIN, SRC_S1,    DST_T,    COND_ALWAYS);
            6'd17: s = mk(ALU_SUB, SRC_N,    SRC_T,     DST_N,    COND_ALWAYS);
            6'd18: s = mk(ALU_SUB, SRC_N,    SRC_S2,    DST_N,    COND_ALWAYS);
            6'd19: s = mk(ALU_ADD, SRC_RT,   SRC_RT,    DST_T,    COND_ALWAYS);
            6'd20: s = mk(ALU_ADD, SRC_T,    SRC_GAIN,  DST_T,    COND_ALWAYS);
            6'd21: s = mk(ALU_MUL, SRC_GAIN, SRC_T,     DST_T,    COND_ALWAYS);
            6'd22: s = mk(ALU_ADD, SRC_KONE, SRC_T,     DST_D,    COND_ALWAYS);
            6'd23: s = mk(ALU_DIV, SRC_N,    SRC_D,     DST_V,    COND_ALWAYS);
            6'd24: s = mk(ALU_MUL, SRC_V,    SRC_GAIN,  DST_T,    COND_ALWAYS);
            6'd25: s = mk(ALU_ADD, SRC_T,    SRC_S1,    DST_Y1,   COND_ALWAYS);
            6'd26: s = mk(ALU_ADD, SRC_T,    SRC_Y1,    DST_S1,   COND_ALWAYS);
            6'd27: s = mk(ALU_MUL, SRC_Y1,   SRC_GAIN,  DST_T,    COND_ALWAYS);
            6'd28: s = mk(ALU_ADD, SRC_T,    SRC_S2,    DST_Y2,   COND_ALWAYS);
            6'd29: s = mk(ALU_ADD, SRC_T,    SRC_Y2,    DST_S2,   COND_ALWAYS);
            6'd30: s = mk(ALU_MUL, SRC_YSEL, SRC_KHALF, DST_A,    COND_HALF);
            6'd31: s = mk(ALU_MUL, SRC_V,    SRC_KHALF, DST_T,    COND_NOTCH);
            6'd32: s = mk(ALU_ADD, SRC_A,    SRC_T,     DST_M,    COND_NOTCH);
            6'd33: s = mk(ALU_MUL, SRC_MSEL, SRC_KGAIN, DST_T,    COND_ALWAYS);
            default: s = mk(ALU_ADD, SRC_T, SRC_T, DST_T, COND_ALWAYS);
        endcase
        return s;
    endfunction

endpackage

[src/svf_alu.sv]
// shared arithmetic unit: saturating add and subtract in the same cycle as start,
// chunked magnitude multiply and bit-serial restoring divide; uses svf_pkg
module svf_alu #(
    parameter int W  = 32,
    parameter int AW = 34
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  svf_pkg::alu_op_t     op,
    input  logic signed [AW-1:0] a,
    input  logic signed [AW-1:0] b,
    output logic                 done,
    output logic signed [W-1:0]  y
);

    localparam int FRAC = svf_pkg::FRAC;
    localparam int CH   = 16;
    localparam int NCH  = (AW + CH - 1) / CH;
    localparam int BW   = NCH * CH;
    localparam int PW   = 2 * AW;
    localparam int DVW  = W + 1 + FRAC;
    localparam int CW   = $clog2(DVW);
    localparam logic [W:0] LIM = {2'b01, {(W-1){1'b0}}};
    localparam logic signed [AW-1:0] VMAX_A =
        $signed({{(AW-W+1){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [AW-1:0] VMIN_A = ~VMAX_A;

    svf_pkg::alu_state_t state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    svf_pkg::alu_op_t    op_reg, op_next;
    logic                neg_reg, neg_next;
    logic                zero_reg, zero_next;
    logic [W-1:0]        zres_reg, zres_next;
    logic [AW-1:0]       ua_reg, ua_next;
    logic [BW-1:0]       ub_reg, ub_next;
    logic [PW-1:0]       acc_reg, acc_next;
    logic [DVW-1:0]      dv_reg, dv_next;
    logic [W:0]          rem_reg, rem_next;
    logic [W:0]          q_reg, q_next;

    logic signed [AW-1:0] sum;
    logic [AW+CH-1:0]     pp;
    logic [PW-1:0]        mr;
    logic [W:0]           mc;
    logic [W:0]           rn;
    logic [W:0]           q1;
    logic [AW-1:0]        mag_num;

    function automatic logic [AW-1:0] mag_a(input logic signed [AW-1:0] x);
        return x[AW-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic signed [W-1:0] sat_w(input logic signed [AW-1:0] x);
        if (x > VMAX_A)
            return VMAX_A[W-1:0];
        if (x < VMIN_A)
            return VMIN_A[W-1:0];
        return x[W-1:0];
    endfunction

    function automatic logic [W-1:0] signed_from(input logic [W:0] m, input logic ng);
        if (m >= LIM)
            return ng ? VMIN_A[W-1:0] : VMAX_A[W-1:0];
        return ng ? (~m[W-1:0] + 1'b1) : m[W-1:0];
    endfunction

    assign sum = (op == svf_pkg::ALU_SUB) ? (a - b) : (a + b);
    assign pp  = ua_reg * ub_reg[BW-1 -: CH];
    assign mr  = acc_reg >> FRAC;
    assign mc  = (mr > PW'(LIM)) ? LIM : mr[W:0];
    assign rn  = {rem_reg[W-1:0], dv_reg[DVW-1]};
    assign q1  = (q_reg <= LIM) ? {q_reg[W-1:0], 1'b0} : q_reg;
    assign mag_num = mag_a(a);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        zres_next  = zres_reg;
        ua_next    = ua_reg;
        ub_next    = ub_reg;
        acc_next   = acc_reg;
        dv_next    = dv_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        done       = 1'b0;
        y          = sat_w(sum);
        unique case (state_reg)
            svf_pkg::AS_IDLE:
            begin
                op_next   = op;
                neg_next  = a[AW-1] ^ b[AW-1];
                zero_next = 1'b0;
                cnt_next  = '0;
                if (start && (op == svf_pkg::ALU_ADD || op == svf_pkg::ALU_SUB))
                begin
                    done = 1'b1;
                end
                else if (start && op == svf_pkg::ALU_MUL)
                begin
                    ua_next    = mag_num;
                    ub_next    = BW'(mag_a(b));
                    acc_next   = '0;
                    state_next = svf_pkg::AS_MUL;
                end
                else if (start && op == svf_pkg::ALU_DIV)
                begin
                    if (b == '0)
                    begin
                        zero_next  = 1'b1;
                        zres_next  = (a == '0) ? '0 :
                                     (a[AW-1] ? VMIN_A[W-1:0] : VMAX_A[W-1:0]);
                        state_next = svf_pkg::AS_DONE;
                    end
                    else
                    begin
                        ua_next    = mag_a(b);
                        dv_next    = {1'b0, mag_num[W-1:0], {FRAC{1'b0}}};
                        rem_next   = '0;
                        q_next     = '0;
                        state_next = svf_pkg::AS_DIV;
                    end
                end
            end
            svf_pkg::AS_MUL:
            begin
                acc_next = (acc_reg << CH) + PW'(pp);
                ub_next  = ub_reg << CH;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(NCH - 1))
                    state_next = svf_pkg::AS_DONE;
            end
            svf_pkg::AS_DIV:
            begin
                dv_next  = dv_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (rn >= ua_reg[W:0])
                begin
                    rem_next = rn - ua_reg[W:0];
                    q_next   = (q1 <= LIM) ? (q1 | (W+1)'(1)) : q1;
                end
                else
                begin
                    rem_next = rn;
                    q_next   = q1;
                end
                if (cnt_reg == CW'(DVW - 1))
                    state_next = svf_pkg::AS_DONE;
            end
            svf_pkg::AS_DONE:
            begin
                done = 1'b1;
                if (zero_reg)
                    y = zres_reg;
                else if (op_reg == svf_pkg::ALU_MUL)
                    y = signed_from(mc, neg_reg);
                else
                    y = signed_from(q_reg, neg_reg);
                state_next = svf_pkg::AS_IDLE;
            end
            default:
            begin
                state_next = svf_pkg::AS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= svf_pkg::AS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        zres_reg <= zres_next;
        ua_reg   <= ua_next;
        ub_reg   <= ub_next;
        acc_reg  <= acc_next;
        dv_reg   <= dv_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

endmodule

[src/svf_ctrl.sv]
// step sequencer: walks the filter program, issues operations to the shared
// unit and hands each word to the output register; uses svf_pkg
module svf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             alu_done,
    input  logic [1:0]       mode,
    input  logic             out_busy,
    output svf_pkg::ctrl_t   ctl
);

    svf_pkg::ctrl_state_t         state_reg, state_next;
    logic [svf_pkg::PC_W-1:0]     pc_reg, pc_next;
    svf_pkg::step_t               step;
    logic                         run;
    logic                         last;
    logic                         adv;

    assign step = svf_pkg::prog_step(pc_reg);
    assign last = (pc_reg == svf_pkg::PC_W'(svf_pkg::PROG_LEN - 1));
    assign run  = (step.cond == svf_pkg::COND_ALWAYS) ||
                  (step.cond == svf_pkg::COND_HALF &&
                   (mode == svf_pkg::MODE_BP || mode == svf_pkg::MODE_NOTCH)) ||
                  (step.cond == svf_pkg::COND_NOTCH && mode == svf_pkg::MODE_NOTCH);

    always_comb
    begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        adv          = 1'b0;
        ctl.in_ready = 1'b0;
        ctl.start    = 1'b0;
        ctl.op       = step.op;
        ctl.src_a    = step.src_a;
        ctl.src_b    = step.src_b;
        ctl.wr_en    = 1'b0;
        ctl.dst      = step.dst;
        ctl.out_load = 1'b0;
        unique case (state_reg)
            svf_pkg::CS_IDLE:
            begin
                ctl.in_ready = 1'b1;
                if (in_valid)
                begin
                    pc_next    = '0;
                    state_next = svf_pkg::CS_ISSUE;
                end
            end
            svf_pkg::CS_ISSUE:
            begin
                if (!run)
                begin
                    adv = 1'b1;
                end
                else
                begin
                    ctl.start = 1'b1;
                    if (alu_done)
                    begin
                        ctl.wr_en = 1'b1;
                        adv       = 1'b1;
                    end
                    else
                    begin
                        state_next = svf_pkg::CS_WAIT;
                    end
                end
            end
            svf_pkg::CS_WAIT:
            begin
                if (alu_done)
                begin
                    ctl.wr_en = 1'b1;
                    adv       = 1'b1;
                end
            end
            svf_pkg::CS_FIN:
            begin
                if (!out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = svf_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = svf_pkg::CS_IDLE;
            end
        endcase
        if (adv)
        begin
            if (last)
            begin
                state_next = svf_pkg::CS_FIN;
            end
            else
            begin
                pc_next    = pc_reg + 1'b1;
                state_next = svf_pkg::CS_ISSUE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= svf_pkg::CS_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

[src/two_pole_multimode_svf_top.sv]
// top level of the two-pole multimode state variable filter: operand
// registers, configuration, output register; uses svf_pkg, svf_alu, svf_ctrl
//
// channel   direction  word              handshake
// s_axis    in         tdata = sample_in  tvalid/tready
// m_axis    out        tdata = sample_out tvalid/tready
// cfg       in         cfg_addr/cfg_wdata cfg_we, no wait
//
// each word runs one bit-serial divide and 11 (lowpass, highpass) to 13 (notch)
// multiplies through the shared unit
// s_axis_tready is high only between words; a finished word waits in the
// output register while the next word is taken in
// reset clears the integrators and loads the start gain and damping
module two_pole_multimode_svf_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // sample_out
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    localparam int W  = DATA_WIDTH;
    localparam int AW = ((DATA_WIDTH > 32) ? DATA_WIDTH : 32) + 2;
    localparam logic signed [AW-1:0] VMAX_A =
        $signed({{(AW-W+1){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [AW-1:0] VMIN_A = ~VMAX_A;
    localparam logic signed [AW-1:0] OMAX_A = AW'(33'sd2147483647);
    localparam logic signed [AW-1:0] OMIN_A = ~OMAX_A;

    function automatic logic signed [W-1:0] sat_w(input logic signed [AW-1:0] x);
        if (x > VMAX_A)
            return VMAX_A[W-1:0];
        if (x < VMIN_A)
            return VMIN_A[W-1:0];
        return x[W-1:0];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [W-1:0] x);
        logic signed [AW-1:0] xa;
        xa = AW'(x);
        if (xa > OMAX_A)
            return OMAX_A[31:0];
        if (xa < OMIN_A)
            return OMIN_A[31:0];
        return xa[31:0];
    endfunction

    svf_pkg::ctrl_t       ctl;
    logic                 alu_done;
    logic signed [W-1:0]  alu_y;
    logic signed [AW-1:0] opa, opb;
    logic                 out_busy;
    logic                 in_take;

    logic signed [W-1:0] s1_reg, s2_reg, gain_reg, damp_reg;
    logic signed [31:0]  gstep_reg, dstep_reg;
    logic [2:0]          mode_reg;
    logic signed [W-1:0] samp_reg, x_reg, p_reg, rt_reg, t_reg, n_reg, d_reg;
    logic signed [W-1:0] v_reg, y1_reg, y2_reg, a_reg, m_reg;
    logic                out_valid_reg;
    logic [31:0]         out_data_reg;

    function automatic logic signed [AW-1:0] pick(input svf_pkg::src_t s);
        logic signed [AW-1:0] r;
        case (s)
            svf_pkg::SRC_S1:    r = AW'(s1_reg);
            svf_pkg::SRC_S2:    r = AW'(s2_reg);
            svf_pkg::SRC_GAIN:  r = AW'(gain_reg);
            svf_pkg::SRC_DAMP:  r = AW'(damp_reg);
            svf_pkg::SRC_SAMP:  r = AW'(samp_reg);
            svf_pkg::SRC_GSTEP: r = AW'(gstep_reg);
            svf_pkg::SRC_DSTEP: r = AW'(dstep_reg);
            svf_pkg::SRC_X:     r = AW'(x_reg);
            svf_pkg::SRC_P:     r = AW'(p_reg);
            svf_pkg::SRC_RT:    r = AW'(rt_reg);
            svf_pkg::SRC_T:     r = AW'(t_reg);
            svf_pkg::SRC_N:     r = AW'(n_reg);
            svf_pkg::SRC_D:     r = AW'(d_reg);
            svf_pkg::SRC_V:     r = AW'(v_reg);
            svf_pkg::SRC_Y1:    r = AW'(y1_reg);
            svf_pkg::SRC_Y2:    r = AW'(y2_reg);
            svf_pkg::SRC_A:     r = AW'(a_reg);
            svf_pkg::SRC_KA:    r = AW'(svf_pkg::K_A);
            svf_pkg::SRC_KB:    r = AW'(svf_pkg::K_B);
            svf_pkg::SRC_KC:    r = AW'(svf_pkg::K_C);
            svf_pkg::SRC_KD:    r = AW'(svf_pkg::K_D);
            svf_pkg::SRC_KX:    r = AW'(svf_pkg::K_X);
            svf_pkg::SRC_KONE:  r = AW'(svf_pkg::K_ONE);
            svf_pkg::SRC_KFB:   r = mode_reg[2] ? AW'(svf_pkg::K_PUSH) : AW'(svf_pkg::K_ONE);
            svf_pkg::SRC_KHALF: r = AW'(svf_pkg::K_HALF);
            svf_pkg::SRC_KGAIN: r = AW'(svf_pkg::K_GAIN);
            svf_pkg::SRC_YSEL:  r = (mode_reg[1:0] == svf_pkg::MODE_BP) ? AW'(y1_reg)
                                                                         : AW'(y2_reg);
            svf_pkg::SRC_MSEL:
            begin
                case (mode_reg[1:0])
                    svf_pkg::MODE_LP: r = AW'(y2_reg);
                    svf_pkg::MODE_BP: r = AW'(a_reg);
                    svf_pkg::MODE_HP: r = AW'(v_reg);
                    default:          r = AW'(m_reg);
                endcase
            end
            default:            r = '0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        opa = pick(ctl.src_a);
        opb = pick(ctl.src_b);
    end

    assign in_take  = s_axis_tvalid && ctl.in_ready;
    assign out_busy = out_valid_reg && !m_axis_tready;

    svf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .alu_done (alu_done),
        .mode     (mode_reg[1:0]),
        .out_busy (out_busy),
        .ctl      (ctl)
    );

    svf_alu #(
        .W  (W),
        .AW (AW)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.start),
        .op    (ctl.op),
        .a     (opa),
        .b     (opb),
        .done  (alu_done),
        .y     (alu_y)
    );

    // filter state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg    <= '0;
            s2_reg    <= '0;
            gain_reg  <= sat_w(AW'(svf_pkg::GAIN_RESET));
            damp_reg  <= '0;
            gstep_reg <= '0;
            dstep_reg <= '0;
            mode_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                svf_pkg::CFG_GAIN_START: gain_reg  <= sat_w(AW'({1'b0, cfg_wdata[30:0]}));
                svf_pkg::CFG_DAMP_START: damp_reg  <= sat_w(AW'($signed(cfg_wdata)));
                svf_pkg::CFG_GAIN_STEP:  gstep_reg <= $signed(cfg_wdata);
                svf_pkg::CFG_DAMP_STEP:  dstep_reg <= $signed(cfg_wdata);
                svf_pkg::CFG_MODE:       mode_reg  <= cfg_wdata[2:0];
                default:
                begin
                end
            endcase
        end
        else if (ctl.wr_en)
        begin
            case (ctl.dst)
                svf_pkg::DST_S1:   s1_reg   <= alu_y;
                svf_pkg::DST_S2:   s2_reg   <= alu_y;
                svf_pkg::DST_GAIN: gain_reg <= alu_y;
                svf_pkg::DST_DAMP: damp_reg <= alu_y;
                default:
                begin
                end
            endcase
        end
    end

    // working values of one word
    always_ff @(posedge clk)
    begin
        if (in_take)
            samp_reg <= sat_w(AW'($signed(s_axis_tdata)));
        if (ctl.wr_en)
        begin
            case (ctl.dst)
                svf_pkg::DST_X:  x_reg  <= alu_y;
                svf_pkg::DST_P:  p_reg  <= alu_y;
                svf_pkg::DST_RT: rt_reg <= alu_y;
                svf_pkg::DST_T:  t_reg  <= alu_y;
                svf_pkg::DST_N:  n_reg  <= alu_y;
                svf_pkg::DST_D:  d_reg  <= alu_y;
                svf_pkg::DST_V:  v_reg  <= alu_y;
                svf_pkg::DST_Y1: y1_reg <= alu_y;
                svf_pkg::DST_Y2: y2_reg <= alu_y;
                svf_pkg::DST_A:  a_reg  <= alu_y;
                svf_pkg::DST_M:  m_reg  <= alu_y;
                default:
                begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
            out_data_reg <= sat32(t_reg);
    end

    assign s_axis_tready = ctl.in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_no_load_over_held: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> !out_busy)
        else $error("output word loaded over a word not yet taken");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input still ready after taking a word");

    a_done_written: assert property (@(posedge clk) disable iff (!rst_n)
        alu_done |-> ctl.wr_en)
        else $error("arithmetic result dropped by the sequencer");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> m_axis_tvalid)
        else $error("loaded word not presented");
`endif

endmodule
